/* sv/gcr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the gradient color ramp.
// Used by every module of the ramp; depends on nothing.
package gcr_pkg;

  localparam int NUM_STOPS  = 7;
  localparam int IDX_W      = $clog2(NUM_STOPS);
  localparam int COUNT_W    = 3;
  localparam int POS_W      = 16;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 4;
  localparam int FRAC_W     = POS_W + 1;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = POS_W / DIV_STAGES;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = POS_W + NUM_CHAN * CHAN_W;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_FIRST = 3'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd2;

  typedef logic [CHAN_W-1:0] chan_t;

  // One stop: position on top, then red, green, blue, alpha (color[3] is red)
  typedef struct packed {
    logic [POS_W-1:0]           pos;
    chan_t [NUM_CHAN-1:0]       color;
  } stop_t;

  typedef enum logic {
    MODE_STOP,
    MODE_BLEND
  } mode_t;

  // Chosen segment, handed from the select stages to the divider
  typedef struct packed {
    mode_t              mode;
    logic [IDX_W-1:0]   idx;
    logic [POS_W-1:0]   offset;
    logic [POS_W-1:0]   span;
  } seg_t;

  // Segment plus its fraction, handed from the divider to the blend stages
  typedef struct packed {
    mode_t              mode;
    logic [IDX_W-1:0]   idx;
    logic [FRAC_W-1:0]  frac;
  } ramp_t;

endpackage

/* sv/gcr_select.sv */
`timescale 1ns / 1ps
// Segment select: two pipeline stages that compare the coordinate against
// every stop and pick the first enclosing segment. Depends on gcr_pkg.
module gcr_select import gcr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [POS_W-1:0]     coord,
  input  logic [COUNT_W-1:0]   stop_count,
  input  stop_t                stops [NUM_STOPS],
  output logic                 seg_valid,
  input  logic                 seg_ready,
  output seg_t                 seg
);

  logic                   v1;
  logic [POS_W-1:0]       t1;
  logic [NUM_STOPS-1:0]   ge1;
  logic [NUM_STOPS-1:0]   le1;
  logic                   ready1;
  logic                   ready2;
  logic [IDX_W-1:0]       last;
  logic [NUM_STOPS-2:0]   hit;
  logic [IDX_W-1:0]       pick;
  logic [IDX_W-1:0]       pick_hi;
  logic                   found;
  seg_t                   seg_next;

  // Each stage moves when it is empty or the next one moves
  assign ready2   = !seg_valid || seg_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // Stage 1: compare the coordinate with every stop position
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      t1 <= coord;
      for (int k = 0; k < NUM_STOPS; k++) begin
        ge1[k] <= coord >= stops[k].pos;
        le1[k] <= coord <= stops[k].pos;
      end
    end
  end

  // Stage 2: clamp the count, take the first enclosing segment
  always_comb begin
    if (stop_count < COUNT_RESET) begin
      last = IDX_W'(1);
    end else begin
      last = IDX_W'(stop_count - COUNT_W'(1));
    end
    for (int k = 0; k < NUM_STOPS - 1; k++) begin
      hit[k] = (IDX_W'(k) < last) && ge1[k] && le1[k+1];
    end
    found = 1'b0;
    pick  = '0;
    for (int k = NUM_STOPS - 2; k >= 0; k--) begin
      if (hit[k]) begin
        found = 1'b1;
        pick  = IDX_W'(k);
      end
    end
    pick_hi = pick + IDX_W'(1);
  end

  always_comb begin
    seg_next = '0;
    if (found) begin
      seg_next.idx    = pick;
      seg_next.offset = t1 - stops[pick].pos;
      seg_next.span   = stops[pick_hi].pos - stops[pick].pos;
      // Zero-length segment: take the color of its first stop
      if (stops[pick_hi].pos == stops[pick].pos) begin
        seg_next.mode = MODE_STOP;
      end else begin
        seg_next.mode = MODE_BLEND;
      end
    end else begin
      // Outside every segment: below the first stop or past the last one
      seg_next.mode = MODE_STOP;
      seg_next.idx  = ge1[0] ? last : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (ready2) begin
      seg_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      seg <= seg_next;
    end
  end

endmodule

/* sv/gcr_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: frac = (offset << 16) / span, a few quotient
// bits per stage over DIV_STAGES stages. Depends on gcr_pkg.
module gcr_div import gcr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    seg_valid,
  output logic    seg_ready,
  input  seg_t    seg,
  output logic    ramp_valid,
  input  logic    ramp_ready,
  output ramp_t   ramp
);

  logic                v     [DIV_STAGES];
  mode_t               mode  [DIV_STAGES];
  logic [IDX_W-1:0]    idx   [DIV_STAGES];
  logic [POS_W-1:0]    span  [DIV_STAGES];
  logic [POS_W-1:0]    rem   [DIV_STAGES];
  logic [FRAC_W-1:0]   quo   [DIV_STAGES];

  logic                in_v    [DIV_STAGES];
  mode_t               in_mode [DIV_STAGES];
  logic [IDX_W-1:0]    in_idx  [DIV_STAGES];
  logic [POS_W-1:0]    in_span [DIV_STAGES];
  logic [POS_W-1:0]    in_rem  [DIV_STAGES];
  logic [FRAC_W-1:0]   in_quo  [DIV_STAGES];
  logic [POS_W-1:0]    nx_rem  [DIV_STAGES];
  logic [FRAC_W-1:0]   nx_quo  [DIV_STAGES];
  logic                rdy     [DIV_STAGES+1];

  assign rdy[DIV_STAGES] = ramp_ready;
  assign seg_ready       = rdy[0];

  // Feed stage 0 from the segment beat, later stages from the stage before
  assign in_v[0]    = seg_valid;
  assign in_mode[0] = seg.mode;
  assign in_idx[0]  = seg.idx;
  assign in_span[0] = seg.span;
  assign in_rem[0]  = seg.offset;
  assign in_quo[0]  = '0;

  for (genvar g = 1; g < DIV_STAGES; g++) begin : g_link
    assign in_v[g]    = v[g-1];
    assign in_mode[g] = mode[g-1];
    assign in_idx[g]  = idx[g-1];
    assign in_span[g] = span[g-1];
    assign in_rem[g]  = rem[g-1];
    assign in_quo[g]  = quo[g-1];
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    assign rdy[g] = !v[g] || rdy[g+1];

    // Shift-subtract steps; stage 0 also settles the integer bit
    always_comb begin : step
      logic [POS_W-1:0]  r;
      logic [POS_W:0]    r2;
      logic [FRAC_W-1:0] q;
      logic              qb;
      r  = in_rem[g];
      q  = in_quo[g];
      r2 = '0;
      if (g == 0) begin
        qb = r >= in_span[g];
        q  = {q[FRAC_W-2:0], qb};
        if (qb) begin
          r = r - in_span[g];
        end
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        r2 = {r, 1'b0};
        qb = r2 >= {1'b0, in_span[g]};
        if (qb) begin
          r2 = r2 - {1'b0, in_span[g]};
        end
        r = r2[POS_W-1:0];
        q = {q[FRAC_W-2:0], qb};
      end
      nx_rem[g] = r;
      nx_quo[g] = q;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g] <= 1'b0;
      end else if (rdy[g]) begin
        v[g] <= in_v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g] && in_v[g]) begin
        mode[g] <= in_mode[g];
        idx[g]  <= in_idx[g];
        span[g] <= in_span[g];
        rem[g]  <= nx_rem[g];
        quo[g]  <= nx_quo[g];
      end
    end
  end

  assign ramp_valid = v[DIV_STAGES-1];
  assign ramp.mode  = mode[DIV_STAGES-1];
  assign ramp.idx   = idx[DIV_STAGES-1];
  assign ramp.frac  = quo[DIV_STAGES-1];

endmodule

/* sv/gcr_blend.sv */
`timescale 1ns / 1ps
// Channel blend: scale each channel difference by the fraction, then add or
// subtract it from the first color into the output register. Depends on gcr_pkg.
module gcr_blend import gcr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ramp_valid,
  output logic                  ramp_ready,
  input  ramp_t                 ramp,
  input  stop_t                 stops [NUM_STOPS],
  output logic                  out_valid,
  input  logic                  out_ready,
  output chan_t [NUM_CHAN-1:0]  color
);

  localparam int PROD_W = FRAC_W + CHAN_W;

  logic                  v1;
  logic                  ready1;
  logic                  ready2;
  chan_t [NUM_CHAN-1:0]  base;
  chan_t [NUM_CHAN-1:0]  mag;
  logic  [NUM_CHAN-1:0]  neg;
  logic  [IDX_W-1:0]     hi_idx;
  chan_t [NUM_CHAN-1:0]  base_next;
  chan_t [NUM_CHAN-1:0]  mag_next;
  logic  [NUM_CHAN-1:0]  neg_next;
  chan_t [NUM_CHAN-1:0]  color_next;

  assign ready2     = !out_valid || out_ready;
  assign ready1     = !v1 || ready2;
  assign ramp_ready = ready1;

  // Stage 1: fetch both colors, multiply the difference by the fraction
  assign hi_idx = (ramp.mode == MODE_BLEND) ? ramp.idx + IDX_W'(1) : ramp.idx;

  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin : chan
      chan_t              a;
      chan_t              b;
      chan_t              diff;
      logic [PROD_W-1:0]  prod;
      a    = stops[ramp.idx].color[ch];
      b    = stops[hi_idx].color[ch];
      neg_next[ch]  = b < a;
      diff = neg_next[ch] ? a - b : b - a;
      prod = PROD_W'(ramp.frac) * PROD_W'(diff);
      base_next[ch] = a;
      if (ramp.mode == MODE_BLEND) begin
        mag_next[ch] = prod[PROD_W-2:FRAC_W-1];
      end else begin
        mag_next[ch] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= ramp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && ramp_valid) begin
      base <= base_next;
      mag  <= mag_next;
      neg  <= neg_next;
    end
  end

  // Stage 2: step from the first color toward the second, into the output
  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      color_next[ch] = neg[ch] ? base[ch] - mag[ch] : base[ch] + mag[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      color <= color_next;
    end
  end

endmodule

/* sv/gradient_color_ramp_core.sv */
`timescale 1ns / 1ps
// Top level of the gradient color ramp: stop registers and the select,
// divide and blend pipelines. Depends on gcr_pkg, gcr_select, gcr_div, gcr_blend.
//
//   channel   handshake            payload
//   input     in_valid/in_ready    coord[15:0]
//   output    out_valid/out_ready  red, green, blue, alpha [7:0]
//   config    cfg_we               cfg_index[2:0], cfg_data[47:0]
//
// One coordinate enters per cycle while the output is not stalled; each color
// passes 2 select stages, 4 divider stages and 2 blend stages.
// Every stage holds its beat while the stage after it is full and stalled;
// empty stages keep filling, so bubbles close up behind a stalled output.
// Reset (rst, synchronous) empties the pipeline, sets the stop count to 2
// and clears all stops to zero.
module gradient_color_ramp_core import gcr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [POS_W-1:0]      coord,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAN_W-1:0]     red,
  output logic [CHAN_W-1:0]     green,
  output logic [CHAN_W-1:0]     blue,
  output logic [CHAN_W-1:0]     alpha,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  logic [COUNT_W-1:0]    stop_count;
  stop_t                 stops [NUM_STOPS];
  logic [IDX_W-1:0]      stop_sel;
  logic                  seg_valid;
  logic                  seg_ready;
  seg_t                  seg;
  logic                  ramp_valid;
  logic                  ramp_ready;
  ramp_t                 ramp;
  chan_t [NUM_CHAN-1:0]  color;

  // Configuration writes
  assign stop_sel = IDX_W'(cfg_index - REG_STOP_FIRST);

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= COUNT_RESET;
      for (int k = 0; k < NUM_STOPS; k++) begin
        stops[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_STOP_COUNT) begin
        stop_count <= cfg_data[COUNT_W-1:0];
      end else begin
        stops[stop_sel] <= cfg_data;
      end
    end
  end

  gcr_select u_select (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .coord      (coord),
    .stop_count (stop_count),
    .stops      (stops),
    .seg_valid  (seg_valid),
    .seg_ready  (seg_ready),
    .seg        (seg)
  );

  gcr_div u_div (
    .clk        (clk),
    .rst        (rst),
    .seg_valid  (seg_valid),
    .seg_ready  (seg_ready),
    .seg        (seg),
    .ramp_valid (ramp_valid),
    .ramp_ready (ramp_ready),
    .ramp       (ramp)
  );

  gcr_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .ramp_valid (ramp_valid),
    .ramp_ready (ramp_ready),
    .ramp       (ramp),
    .stops      (stops),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .color      (color)
  );

  assign red   = color[3];
  assign green = color[2];
  assign blue  = color[1];
  assign alpha = color[0];

endmodule

/* sv/gcr_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the gradient color ramp, bound to the top level.
// Depends on gcr_pkg and gradient_color_ramp_core.
module gcr_checker import gcr_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CHAN_W-1:0]  red,
  input logic [CHAN_W-1:0]  green,
  input logic [CHAN_W-1:0]  blue,
  input logic [CHAN_W-1:0]  alpha
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present right after reset");

  // An empty output means every stage can take a beat
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  // A stalled color holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
      && $stable(blue) && $stable(alpha))
    else $error("stalled output beat changed");

  // No color rises straight out of reset
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(rst))
    else $error("output beat appeared out of reset");

endmodule

bind gradient_color_ramp_core gcr_checker u_gcr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .red       (red),
  .green     (green),
  .blue      (blue),
  .alpha     (alpha)
);
